// File: sv/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types, codes and widths of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

	localparam int MAX_SLOTS_DEF = 1024;

	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	localparam logic [COUNT_W-1:0] NUM_SLOTS_RST = 11'd1024;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC    = 2'd0,
		KIND_FREE     = 2'd1,
		KIND_CONTAINS = 2'd2,
		KIND_INIT     = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OOR      = 2'd2,
		ST_NOT_INIT = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic walk_start;
		logic walk_step;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_init;
		logic walk_last;
	} sts_t;

endpackage

// File: sv/fbfl_req_if.sv
// ----------------------------------------------------------------------------
// fbfl_req_if
// Request channel: valid/ready handshake carrying kind and slot.
// ----------------------------------------------------------------------------
interface fbfl_req_if;

	logic                        valid;
	logic                        ready;
	logic [fbfl_pkg::KIND_W-1:0] kind;
	logic [fbfl_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output kind, output slot, input ready);
	modport sink (input valid, input kind, input slot, output ready);

endinterface

// File: sv/fbfl_rsp_if.sv
// ----------------------------------------------------------------------------
// fbfl_rsp_if
// Response channel: valid/ready handshake carrying the allocator result.
// ----------------------------------------------------------------------------
interface fbfl_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [fbfl_pkg::STATUS_W-1:0] status;
	logic [fbfl_pkg::SLOT_W-1:0]   granted_slot;
	logic                          in_pool;
	logic [fbfl_pkg::COUNT_W-1:0]  free_count;
	logic                          initialized;

	modport source (
		output valid, output status, output granted_slot, output in_pool,
		output free_count, output initialized, input ready
	);
	modport sink (
		input valid, input status, input granted_slot, input in_pool,
		input free_count, input initialized, output ready
	);

endinterface

// File: sv/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-size slots kept as a LIFO free list of next-slot links.
// ----------------------------------------------------------------------------
// One request is in flight at a time. For alloc, free and contains, the
// accept cycle reads the head slot's link from the link RAM, and the exec
// state, once the output register is free, applies the operation and loads
// the response register. Init runs a walk over the effective pool size that
// writes one link per cycle through the RAM's single write port. A new
// request is taken while a previous response still waits in the output
// register. num_slots is sampled only when an init request starts; 0 is
// taken as 1 and values above MAX_SLOTS as MAX_SLOTS.
module fixed_block_free_list_allocator #(
	parameter int MAX_SLOTS = fbfl_pkg::MAX_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fbfl_pkg::COUNT_W-1:0] cfg_wdata,
	fbfl_req_if.sink                     req,
	fbfl_rsp_if.source                   rsp
);

	fbfl_pkg::cmd_t cmd;
	fbfl_pkg::sts_t sts;

	fbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fbfl_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_kind     (req.kind),
		.req_slot     (req.slot),
		.cmd          (cmd),
		.sts          (sts),
		.status       (rsp.status),
		.granted_slot (rsp.granted_slot),
		.in_pool      (rsp.in_pool),
		.free_count   (rsp.free_count),
		.initialized  (rsp.initialized)
	);

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	a_uninit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.initialized |->
		rsp.status == fbfl_pkg::ST_NOT_INIT && rsp.free_count == '0)
		else $error("response before init is not a not-initialized response");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == fbfl_pkg::ST_EMPTY |->
		rsp.granted_slot == '0 && rsp.free_count == '0)
		else $error("empty pool response with a slot or a nonzero count");

	a_init_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.in_pool |-> rsp.initialized && rsp.status == fbfl_pkg::ST_OK)
		else $error("contains hit on an uninitialized or failed response");
`endif

endmodule

// File: sv/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Controller: sequences accept, execute, init walk and result hand-off.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  fbfl_pkg::sts_t sts,
	output fbfl_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   res_free;
	logic   load;

	assign res_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_EXEC: begin
				cmd.walk_start = sts.is_init;
				cmd.exec       = !sts.is_init && res_free;
			end
			S_WALK: cmd.walk_step = 1'b1;
			S_FIN:  cmd.fin = res_free;
			default: cmd = '0;
		endcase
	end

	assign load = cmd.exec || cmd.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (req_valid) begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (sts.is_init) begin
						state_q <= S_WALK;
					end else if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				S_WALK: if (sts.walk_last) begin
					state_q <= S_FIN;
				end
				S_FIN: if (res_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/fbfl_dp.sv
// ----------------------------------------------------------------------------
// fbfl_dp
// Datapath: head, free count, pool size, link RAM and result registers.
// ----------------------------------------------------------------------------
module fbfl_dp #(
	parameter int MAX_SLOTS = fbfl_pkg::MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fbfl_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic [fbfl_pkg::KIND_W-1:0]   req_kind,
	input  logic [fbfl_pkg::SLOT_W-1:0]   req_slot,
	input  fbfl_pkg::cmd_t                cmd,
	output fbfl_pkg::sts_t                sts,
	output logic [fbfl_pkg::STATUS_W-1:0] status,
	output logic [fbfl_pkg::SLOT_W-1:0]   granted_slot,
	output logic                          in_pool,
	output logic [fbfl_pkg::COUNT_W-1:0]  free_count,
	output logic                          initialized
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam logic [CW-1:0] NULL_LINK = CW'(MAX_SLOTS);

	logic [fbfl_pkg::COUNT_W-1:0] num_q;
	logic [CW-1:0]                head_q;
	logic [CW-1:0]                free_q;
	logic [CW-1:0]                pool_q;
	logic                         ready_q;
	logic [AW-1:0]                cnt_q;
	fbfl_pkg::kind_t              kind_q;
	logic [fbfl_pkg::SLOT_W-1:0]  slot_q;

	logic [CW-1:0] n_eff;
	logic          head_null;
	logic          slot_in;
	logic          alloc_ok;
	logic          free_ok;
	logic [CW-1:0] free_nxt;
	logic [CW-1:0] cnt_inc;
	logic          walk_last;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [CW-1:0] mem_rdata;
	fbfl_pkg::status_t st;

	always_comb begin
		if (num_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(num_q) > 32'(MAX_SLOTS)) begin
			n_eff = NULL_LINK;
		end else begin
			n_eff = CW'(num_q);
		end
	end

	assign head_null = (head_q == NULL_LINK);
	assign slot_in   = 32'(slot_q) < 32'(pool_q);
	assign alloc_ok  = ready_q && (kind_q == fbfl_pkg::KIND_ALLOC) && !head_null;
	assign free_ok   = ready_q && (kind_q == fbfl_pkg::KIND_FREE) && slot_in;
	assign cnt_inc   = CW'(cnt_q) + CW'(1);
	assign walk_last = (cnt_inc == pool_q);

	assign sts.is_init   = (kind_q == fbfl_pkg::KIND_INIT);
	assign sts.walk_last = walk_last;

	always_comb begin
		free_nxt = free_q;
		if (alloc_ok && free_q != '0) begin
			free_nxt = free_q - CW'(1);
		end else if (free_ok && free_q < pool_q) begin
			free_nxt = free_q + CW'(1);
		end
	end

	always_comb begin
		if (!ready_q) begin
			st = fbfl_pkg::ST_NOT_INIT;
		end else if (kind_q == fbfl_pkg::KIND_ALLOC && head_null) begin
			st = fbfl_pkg::ST_EMPTY;
		end else if (kind_q == fbfl_pkg::KIND_FREE && !slot_in) begin
			st = fbfl_pkg::ST_OOR;
		end else begin
			st = fbfl_pkg::ST_OK;
		end
	end

	// walk writes the init chain; exec writes a pushed slot's link
	assign mem_we    = cmd.walk_step || (cmd.exec && free_ok);
	assign mem_waddr = cmd.walk_step ? cnt_q : AW'(slot_q);
	assign mem_wdata = cmd.walk_step ? (walk_last ? NULL_LINK : cnt_inc) : head_q;

	fbfl_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (AW'(head_q)),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= fbfl_pkg::NUM_SLOTS_RST;
			head_q  <= NULL_LINK;
			free_q  <= '0;
			pool_q  <= '0;
			ready_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_q <= cfg_wdata;
			end
			if (cmd.walk_start) begin
				pool_q <= n_eff;
			end
			if (cmd.walk_step && walk_last) begin
				head_q  <= '0;
				free_q  <= pool_q;
				ready_q <= 1'b1;
			end
			if (cmd.exec) begin
				free_q <= free_nxt;
				if (alloc_ok) begin
					head_q <= mem_rdata;
				end else if (free_ok) begin
					head_q <= CW'(slot_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= fbfl_pkg::kind_t'(req_kind);
			slot_q <= req_slot;
		end
		if (cmd.walk_start) begin
			cnt_q <= '0;
		end else if (cmd.walk_step) begin
			cnt_q <= cnt_q + AW'(1);
		end
		if (cmd.exec) begin
			status       <= st;
			granted_slot <= alloc_ok ? fbfl_pkg::SLOT_W'(head_q) : '0;
			in_pool      <= ready_q && (kind_q == fbfl_pkg::KIND_CONTAINS) && slot_in;
			free_count   <= fbfl_pkg::COUNT_W'(free_nxt);
			initialized  <= ready_q;
		end else if (cmd.fin) begin
			status       <= fbfl_pkg::ST_OK;
			granted_slot <= '0;
			in_pool      <= 1'b0;
			free_count   <= fbfl_pkg::COUNT_W'(free_q);
			initialized  <= 1'b1;
		end
	end

endmodule

// File: dv/fbfl_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_alloc_checker
// Watches the request, response and configuration ports of the free list
// allocator. Keeps its own copy of the link memory, head, free count and pool
// size, predicts one response per accepted request and compares every
// accepted response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fbfl_alloc_checker
	import fbfl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	fbfl_req_if                req,
	fbfl_rsp_if                rsp,
	output int                 fails,
	output int                 outstanding
);

	localparam int MAX_SLOTS = MAX_SLOTS_DEF;
	localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(MAX_SLOTS);

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   granted_slot;
		logic                in_pool;
		logic [COUNT_W-1:0]  free_count;
		logic                initialized;
	} alloc_result_t;

	logic [COUNT_W-1:0] link_mem [MAX_SLOTS];
	logic [COUNT_W-1:0] head_slot;
	logic [COUNT_W-1:0] free_slots;
	logic [COUNT_W-1:0] pool_len;
	logic [COUNT_W-1:0] cfg_slots;
	logic               pool_ready;
	alloc_result_t      pending_q [$];
	int                 fail_total;

	function automatic alloc_result_t predict_alloc(input kind_t k,
			input logic [SLOT_W-1:0] s);
		alloc_result_t r;
		logic [COUNT_W-1:0] n;
		r = '0;
		r.status = ST_OK;
		if (k == KIND_INIT) begin
			n = cfg_slots;
			if (n == 0) n = COUNT_W'(1);
			if (n > MAX_SLOTS) n = COUNT_W'(MAX_SLOTS);
			for (int i = 0; i + 1 < n; i++)
				link_mem[SLOT_W'(i)] = COUNT_W'(i + 1);
			link_mem[SLOT_W'(n - 1'b1)] = NULL_LINK;
			head_slot  = '0;
			free_slots = n;
			pool_len   = n;
			pool_ready = 1'b1;
		end else if (!pool_ready) begin
			r.status = ST_NOT_INIT;
		end else begin
			case (k)
				KIND_ALLOC: begin
					if (head_slot < MAX_SLOTS) begin
						r.granted_slot = head_slot[SLOT_W-1:0];
						head_slot = link_mem[head_slot[SLOT_W-1:0]];
						if (free_slots > 0) free_slots = free_slots - 1'b1;
					end else begin
						r.status = ST_EMPTY;
					end
				end
				KIND_FREE: begin
					if ({1'b0, s} < pool_len) begin
						link_mem[s] = head_slot;
						head_slot = {1'b0, s};
						if (free_slots < pool_len) free_slots = free_slots + 1'b1;
					end else begin
						r.status = ST_OOR;
					end
				end
				default: begin
					r.in_pool = ({1'b0, s} < pool_len);
				end
			endcase
		end
		r.free_count  = free_slots;
		r.initialized = pool_ready;
		return r;
	endfunction

	function automatic bit field_ok(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		bit ok;
		if (!arst_n) begin
			cfg_slots  = NUM_SLOTS_RST;
			head_slot  = NULL_LINK;
			free_slots = '0;
			pool_len   = '0;
			pool_ready = 1'b0;
			fail_total = 0;
			pending_q.delete();
			fails       <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we === 1'b1) cfg_slots = cfg_wdata;
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual status %0d slot %0d",
						$time, rsp.status, rsp.granted_slot);
					fail_total++;
				end else begin
					want = pending_q.pop_front();
					ok = field_ok("status", want.status, rsp.status)
						& field_ok("granted_slot", want.granted_slot, rsp.granted_slot)
						& field_ok("in_pool", want.in_pool, rsp.in_pool)
						& field_ok("free_count", want.free_count, rsp.free_count)
						& field_ok("initialized", want.initialized, rsp.initialized);
					if (!ok) fail_total++;
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				pending_q.push_back(predict_alloc(kind_t'(req.kind), req.slot));
			fails       <= fail_total;
			outstanding <= pending_q.size();
		end
	end

endmodule

// File: dv/fixed_block_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_tb
// Drives alloc, free, contains and init requests into the allocator with
// random gaps and response stalls, rewrites the pool size between phases
// while idle, and reports the verdict from the checker's counters.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_tb;

	import fbfl_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;
	int                 fails;
	int                 outstanding;

	bit src_nogap;
	bit rsp_nostall;
	bit hold_request;
	int cfg_val;
	int pool_n;

	fbfl_req_if req_bus ();
	fbfl_rsp_if rsp_bus ();

	fixed_block_free_list_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	fbfl_alloc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_bus),
		.rsp         (rsp_bus),
		.fails       (fails),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(8_000_000);
		$display("** fixed_block_free_list_allocator: FAILED **");
		$finish;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_req(input kind_t k, input int s);
		int g;
		g = src_nogap ? 0 : rand_gap();
		if (g > 0) begin
			req_bus.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		if (k == KIND_INIT)
			pool_n = (cfg_val == 0) ? 1 : ((cfg_val > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cfg_val);
		req_bus.valid <= 1'b1;
		req_bus.kind  <= k;
		req_bus.slot  <= SLOT_W'(s);
		do @(posedge clk); while (req_bus.ready !== 1'b1);
	endtask

	task automatic drain();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_slots(input int v);
		cfg_val = v;
		cfg_we    <= 1'b1;
		cfg_wdata <= COUNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int slots, input int count);
		int r;
		write_slots(slots);
		send_req(KIND_INIT, $urandom_range(0, 1023));
		for (int i = 1; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				send_req(KIND_ALLOC, $urandom_range(0, 1023));
			else if (r < 75)
				send_req(KIND_FREE, ($urandom_range(0, 4) != 0) ?
					$urandom_range(0, pool_n - 1) : $urandom_range(0, 1023));
			else if (r < 92)
				send_req(KIND_CONTAINS, $urandom_range(0, 1) ?
					$urandom_range(0, (pool_n < 1023) ? pool_n + 1 : 1023) :
					$urandom_range(0, 1023));
			else if (r < 95)
				send_req(KIND_INIT, $urandom_range(0, 1023));
			else
				send_req(kind_t'($urandom_range(0, 3)), $urandom_range(0, 1023));
		end
		drain();
	endtask

	// response side: random stalls, an optional long hold-off, or always ready
	initial begin
		int g;
		rsp_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				rsp_bus.ready <= 1'b0;
				repeat (100) @(posedge clk);
				hold_request = 1'b0;
			end else if (rsp_nostall) begin
				rsp_bus.ready <= 1'b1;
				@(posedge clk);
			end else begin
				g = rand_gap();
				if (g > 0) begin
					rsp_bus.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				rsp_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int phase_slots [10];
		req_bus.valid = 1'b0;
		req_bus.kind  = KIND_ALLOC;
		req_bus.slot  = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		src_nogap     = 1'b0;
		rsp_nostall   = 1'b0;
		hold_request  = 1'b0;
		cfg_val       = NUM_SLOTS_RST;
		pool_n        = 0;
		arst_n        = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before init, then init with the reset pool size
		send_req(KIND_ALLOC, 0);
		send_req(KIND_FREE, 5);
		send_req(KIND_CONTAINS, 0);
		send_req(KIND_INIT, 1023);
		send_req(KIND_CONTAINS, 1023);
		send_req(KIND_ALLOC, 0);
		send_req(KIND_FREE, 1023);
		send_req(KIND_ALLOC, 0);
		drain();

		// small pool: drain to empty, out of range, double free, count floor
		write_slots(4);
		send_req(KIND_INIT, 0);
		send_req(KIND_CONTAINS, 3);
		send_req(KIND_CONTAINS, 4);
		repeat (5) send_req(KIND_ALLOC, 1023);
		send_req(KIND_FREE, 1023);
		send_req(KIND_FREE, 4);
		send_req(KIND_FREE, 3);
		send_req(KIND_FREE, 3);
		repeat (3) send_req(KIND_ALLOC, 0);
		drain();

		// zero pool size taken as one, free count saturates
		write_slots(0);
		send_req(KIND_INIT, 0);
		send_req(KIND_FREE, 0);
		send_req(KIND_ALLOC, 0);
		send_req(KIND_CONTAINS, 1);
		drain();

		phase_slots = '{1024, 8, 0, 2047, 1, 2, 1025, 16, 0, 0};
		phase_slots[8] = $urandom_range(3, 40);
		phase_slots[9] = $urandom_range(0, 2047);
		for (int p = 0; p < 10; p++) begin
			src_nogap    = (p < 2);
			rsp_nostall  = (p == 1);
			hold_request = (p == 0);
			run_phase(phase_slots[p], 85);
		end

		repeat (20) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("** fixed_block_free_list_allocator: PASSED **");
		else
			$display("** fixed_block_free_list_allocator: FAILED **");
		$finish;
	end

endmodule
